/* design/ppoc_pkg.sv */
// ----------------------------------------------------------------------------
// ppoc_pkg
// Shared types, codes and helpers of the pin power output controller.
// ----------------------------------------------------------------------------
package ppoc_pkg;

    // Fixed field widths
    localparam int unsigned PIN_W    = 5;
    localparam int unsigned LEVEL_W  = 8;
    localparam int unsigned OP_W     = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 5;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL  = 8'hff;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 8'hff;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_SELECT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_SELECT = 2'd1;

    // Command codes; the two remaining codes are ignored
    typedef enum logic [OP_W-1:0] {
        OP_SET_POWER = 3'd0,
        OP_ON        = 3'd1,
        OP_OFF       = 3'd2,
        OP_LEFT      = 3'd3,
        OP_RIGHT     = 3'd4,
        OP_STOP_ALL  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_EMIT,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [LEVEL_W-1:0] level;
    } t_in_item;

    typedef struct packed {
        logic [PIN_W-1:0]   pin_index;
        logic               pwm_enable;
        logic [LEVEL_W-1:0] duty;
        logic               drive_high;
        logic               last;
    } t_out_item;

    // Pins wired to a PWM compare channel
    function automatic logic pin_is_pwm(input logic [PIN_W-1:0] pin);
        return (pin == 5'd3) || (pin == 5'd5) || (pin == 5'd6) ||
               (pin == 5'd9) || (pin == 5'd10) || (pin == 5'd11);
    endfunction

endpackage

/* design/ppoc_drive.sv */
// ----------------------------------------------------------------------------
// ppoc_drive
// Drive resolver shared by every result: turns pin, on bit and stored level
// into PWM enable, duty and plain output level.
// ----------------------------------------------------------------------------
module ppoc_drive (
    input  logic [ppoc_pkg::PIN_W-1:0]   i_pin,
    input  logic                         i_on,
    input  logic [ppoc_pkg::LEVEL_W-1:0] i_level,
    input  logic                         i_last,
    output ppoc_pkg::t_out_item          o_item
);

    logic [ppoc_pkg::LEVEL_W-1:0] eff_level;
    logic                         level_nz;
    logic                         pwm;

    // Effective level is zero while the pin is off
    assign eff_level = i_on ? i_level : '0;
    assign level_nz  = (eff_level != '0);
    assign pwm       = ppoc_pkg::pin_is_pwm(i_pin) && level_nz &&
                       (eff_level != ppoc_pkg::FULL_LEVEL);

    always_comb begin
        o_item.pin_index  = i_pin;
        o_item.pwm_enable = pwm;
        o_item.duty       = pwm ? eff_level : '0;
        o_item.drive_high = !pwm && level_nz;
        o_item.last       = i_last;
    end

endmodule

/* design/pin_power_output_controller_core.sv */
// ----------------------------------------------------------------------------
// pin_power_output_controller_core
// Per-pin power level and on bit store with a small sequencer that resolves
// and reports pin drive for each applied pin command and stop-all cleared pin.
// ----------------------------------------------------------------------------
// One command is taken at a time. For set power, on, off, left and right the
// state is updated in S_APPLY, then the pin is resolved and loaded into the
// output register in S_EMIT; the next command is taken once the sequencer is
// back in idle. Stop all walks the pins one per cycle, while the output is
// not stalled, through the single drive resolver and ends early once no pin
// is left on. A command on a pin at or above PIN_COUNT, or an unused op code,
// is dropped in the transfer cycle with no result. A stalled output holds the
// sequencer until its result is taken.
module pin_power_output_controller_core #(
    parameter int unsigned PIN_COUNT = 21
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Command channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  ppoc_pkg::t_in_item             i_in_data,
    // Result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output ppoc_pkg::t_out_item            o_out_data,
    // Configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ppoc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ppoc_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    localparam int unsigned IDX_W = $clog2(PIN_COUNT);
    localparam logic [PIN_COUNT-1:0] PIN_ONE = PIN_COUNT'(1);
    localparam logic [ppoc_pkg::PIN_W:0] PIN_LIMIT = (ppoc_pkg::PIN_W + 1)'(PIN_COUNT);

    // Registers
    ppoc_pkg::t_state             r_state, n_state;
    logic [IDX_W-1:0]             r_pin, n_pin;
    logic [ppoc_pkg::OP_W-1:0]    r_op, n_op;
    logic [ppoc_pkg::LEVEL_W-1:0] r_level, n_level;
    logic [PIN_COUNT-1:0]         r_on_mask, n_on_mask;
    logic [ppoc_pkg::LEVEL_W-1:0] r_levels [PIN_COUNT];
    logic [ppoc_pkg::PIN_W-1:0]   r_power_sel, r_dir_sel;
    logic                         r_out_valid, n_out_valid;
    ppoc_pkg::t_out_item          r_out;

    logic                         in_xfer;
    logic                         slot_free;
    logic                         out_load;
    logic                         level_we;
    logic                         drv_on;
    logic                         drv_last;
    logic [ppoc_pkg::PIN_W-1:0]   drv_pin;
    logic [PIN_COUNT-1:0]         pin_bit;
    logic [PIN_COUNT-1:0]         mask_clr;
    ppoc_pkg::t_out_item          drv_item;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ppoc_pkg::S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign slot_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign pin_bit  = PIN_ONE << r_pin;
    assign mask_clr = r_on_mask & ~pin_bit;
    assign drv_pin  = ppoc_pkg::PIN_W'(r_pin);

    // Shared drive resolver
    ppoc_drive u_drive (
        .i_pin   (drv_pin),
        .i_on    (drv_on),
        .i_level (r_levels[r_pin]),
        .i_last  (drv_last),
        .o_item  (drv_item)
    );

    // Sequencer: next state and datapath controls
    always_comb begin
        n_state     = r_state;
        n_pin       = r_pin;
        n_op        = r_op;
        n_level     = r_level;
        n_on_mask   = r_on_mask;
        level_we    = 1'b0;
        out_load    = 1'b0;
        drv_on      = 1'b0;
        drv_last    = 1'b1;

        unique case (r_state)
            ppoc_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_op    = i_in_data.op;
                    n_level = i_in_data.level;
                    unique case (i_in_data.op)
                        ppoc_pkg::OP_SET_POWER, ppoc_pkg::OP_ON, ppoc_pkg::OP_OFF: begin
                            if ({1'b0, r_power_sel} < PIN_LIMIT) begin
                                n_pin   = r_power_sel[IDX_W-1:0];
                                n_state = ppoc_pkg::S_APPLY;
                            end
                        end
                        ppoc_pkg::OP_LEFT, ppoc_pkg::OP_RIGHT: begin
                            if ({1'b0, r_dir_sel} < PIN_LIMIT) begin
                                n_pin   = r_dir_sel[IDX_W-1:0];
                                n_state = ppoc_pkg::S_APPLY;
                            end
                        end
                        ppoc_pkg::OP_STOP_ALL: begin
                            n_pin   = '0;
                            n_state = ppoc_pkg::S_SCAN;
                        end
                        // Unused codes are dropped
                        default: ;
                    endcase
                end
            end

            // Update the store for the selected pin
            ppoc_pkg::S_APPLY: begin
                unique case (r_op)
                    ppoc_pkg::OP_SET_POWER:            level_we  = 1'b1;
                    ppoc_pkg::OP_ON, ppoc_pkg::OP_LEFT: n_on_mask = r_on_mask | pin_bit;
                    ppoc_pkg::OP_OFF, ppoc_pkg::OP_RIGHT: n_on_mask = mask_clr;
                    default: ;
                endcase
                n_state = ppoc_pkg::S_EMIT;
            end

            // Resolve the single pin and hand it to the output register
            ppoc_pkg::S_EMIT: begin
                drv_on = r_on_mask[r_pin];
                if (slot_free) begin
                    out_load = 1'b1;
                    n_state  = ppoc_pkg::S_IDLE;
                end
            end

            // Stop all: one pin a cycle unless the output is stalled, report and clear each pin found on
            ppoc_pkg::S_SCAN: begin
                drv_last = (mask_clr == '0);
                if (r_on_mask == '0) begin
                    n_state = ppoc_pkg::S_IDLE;
                end else if (!r_on_mask[r_pin]) begin
                    n_pin = r_pin + IDX_W'(1);
                end else if (slot_free) begin
                    out_load  = 1'b1;
                    n_on_mask = mask_clr;
                    n_pin     = r_pin + IDX_W'(1);
                    if (drv_last) begin
                        n_state = ppoc_pkg::S_IDLE;
                    end
                end
            end

            default: n_state = ppoc_pkg::S_IDLE;
        endcase

        // Output register valid
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ppoc_pkg::S_IDLE;
            r_on_mask   <= '0;
            r_out_valid <= 1'b0;
            r_power_sel <= '0;
            r_dir_sel   <= '0;
        end else begin
            r_state     <= n_state;
            r_on_mask   <= n_on_mask;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == ppoc_pkg::CFG_POWER_SELECT) begin
                    r_power_sel <= i_cfg_data;
                end else if (i_cfg_index == ppoc_pkg::CFG_DIRECTION_SELECT) begin
                    r_dir_sel <= i_cfg_data;
                end
            end
        end
    end

    // Power level store, all full after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIN_COUNT; i++) begin
                r_levels[i] <= ppoc_pkg::LEVEL_RESET;
            end
        end else if (level_we) begin
            r_levels[r_pin] <= r_level;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pin   <= n_pin;
        r_op    <= n_op;
        r_level <= n_level;
        if (out_load) begin
            r_out <= drv_item;
        end
    end

endmodule

/* design/ppoc_checker.sv */
// ----------------------------------------------------------------------------
// ppoc_checker
// Port-level checks of the pin power output controller, bound to the core.
// ----------------------------------------------------------------------------
module ppoc_checker #(
    parameter int unsigned PIN_COUNT = 21
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ppoc_pkg::t_out_item o_out_data
);

    // A stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Reported pin lies inside the pin range
    a_pin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_out_data.pin_index} < (ppoc_pkg::PIN_W + 1)'(PIN_COUNT)))
        else $error("pin index out of range");

    // PWM only on a PWM pin, with a duty strictly inside the range
    a_pwm_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.pwm_enable |->
            ppoc_pkg::pin_is_pwm(o_out_data.pin_index) &&
            o_out_data.duty != '0 && o_out_data.duty != ppoc_pkg::FULL_LEVEL &&
            !o_out_data.drive_high)
        else $error("malformed PWM drive");

    // Plain drive carries no duty
    a_plain_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.pwm_enable |-> o_out_data.duty == '0)
        else $error("duty set without PWM");

endmodule

bind pin_power_output_controller_core ppoc_checker #(.PIN_COUNT(PIN_COUNT)) u_ppoc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

/* test/pin_power_output_controller_core_tb.sv */
// ----------------------------------------------------------------------------
// pin_power_output_controller_core_tb
// Self-checking bench for the pin power output controller. Commands are sent
// under random idling on both channels; a local copy of the power levels, on
// bits and pin selects predicts every reported pin drive, and each result
// transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module pin_power_output_controller_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NPINS        = 21;
    localparam int unsigned DRAIN_CYCLES = 32;

    // Op codes the block ignores
    localparam logic [ppoc_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [ppoc_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;

    // Register indexes with no register behind them
    localparam logic [ppoc_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [ppoc_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    ppoc_pkg::t_in_item             i_in_data = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    ppoc_pkg::t_out_item            o_out_data;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [ppoc_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ppoc_pkg::CFG_DAT_W-1:0] i_cfg_data = '0;

    // Local copy of the block state
    logic [ppoc_pkg::LEVEL_W-1:0] power_lvl [NPINS];
    logic [NPINS-1:0]             on_bits;
    logic [ppoc_pkg::PIN_W-1:0]   pwr_sel_pin;
    logic [ppoc_pkg::PIN_W-1:0]   dir_pin;

    ppoc_pkg::t_out_item drive_q [$];
    int unsigned mismatch_count = 0;
    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;

    pin_power_output_controller_core #(
        .PIN_COUNT (NPINS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Give up on a hung run
    initial begin
        #(20_000_000);
        $display("[pin_power_output_controller_core] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // Drive prediction
    // ------------------------------------------------------------------------
    function automatic logic is_pwm_pin(input logic [ppoc_pkg::PIN_W-1:0] pin);
        case (pin)
            5'd3, 5'd5, 5'd6, 5'd9, 5'd10, 5'd11: return 1'b1;
            default:                              return 1'b0;
        endcase
    endfunction

    function automatic ppoc_pkg::t_out_item resolve_drive(
        input logic [ppoc_pkg::PIN_W-1:0] pin,
        input logic                       is_last
    );
        ppoc_pkg::t_out_item          d;
        logic [ppoc_pkg::LEVEL_W-1:0] eff;
        logic                         pwm;
        eff          = on_bits[pin] ? power_lvl[pin] : '0;
        pwm          = is_pwm_pin(pin) && (eff != '0) && (eff != ppoc_pkg::FULL_LEVEL);
        d.pin_index  = pin;
        d.pwm_enable = pwm;
        d.duty       = pwm ? eff : '0;
        d.drive_high = !pwm && (eff != '0);
        d.last       = is_last;
        return d;
    endfunction

    // Update the state for one accepted command and queue its drives
    task automatic apply_command(input ppoc_pkg::t_in_item cmd);
        int unsigned n_on;
        int unsigned k;
        case (cmd.op)
            ppoc_pkg::OP_SET_POWER: if (pwr_sel_pin < NPINS) begin
                power_lvl[pwr_sel_pin] = cmd.level;
                drive_q.push_back(resolve_drive(pwr_sel_pin, 1'b1));
            end
            ppoc_pkg::OP_ON: if (pwr_sel_pin < NPINS) begin
                on_bits[pwr_sel_pin] = 1'b1;
                drive_q.push_back(resolve_drive(pwr_sel_pin, 1'b1));
            end
            ppoc_pkg::OP_OFF: if (pwr_sel_pin < NPINS) begin
                on_bits[pwr_sel_pin] = 1'b0;
                drive_q.push_back(resolve_drive(pwr_sel_pin, 1'b1));
            end
            ppoc_pkg::OP_LEFT: if (dir_pin < NPINS) begin
                on_bits[dir_pin] = 1'b1;
                drive_q.push_back(resolve_drive(dir_pin, 1'b1));
            end
            ppoc_pkg::OP_RIGHT: if (dir_pin < NPINS) begin
                on_bits[dir_pin] = 1'b0;
                drive_q.push_back(resolve_drive(dir_pin, 1'b1));
            end
            ppoc_pkg::OP_STOP_ALL: begin
                // each pin that was on, lowest first, reported after clearing
                n_on = $countones(on_bits);
                k    = 0;
                for (int p = 0; p < NPINS; p++) begin
                    if (on_bits[p]) begin
                        on_bits[p] = 1'b0;
                        k++;
                        drive_q.push_back(resolve_drive(ppoc_pkg::PIN_W'(p), k == n_on));
                    end
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall and checking
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin : check_results
        ppoc_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (drive_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result for pin %0d",
                                          o_out_data.pin_index));
            end else begin
                want = drive_q.pop_front();
                if (o_out_data.pin_index !== want.pin_index)
                    report_mismatch($sformatf("pin_index %0d, expected %0d",
                                              o_out_data.pin_index, want.pin_index));
                if (o_out_data.pwm_enable !== want.pwm_enable)
                    report_mismatch($sformatf("pin %0d pwm_enable %b, expected %b",
                                              want.pin_index, o_out_data.pwm_enable,
                                              want.pwm_enable));
                if (o_out_data.duty !== want.duty)
                    report_mismatch($sformatf("pin %0d duty %0d, expected %0d",
                                              want.pin_index, o_out_data.duty,
                                              want.duty));
                if (o_out_data.drive_high !== want.drive_high)
                    report_mismatch($sformatf("pin %0d drive_high %b, expected %b",
                                              want.pin_index, o_out_data.drive_high,
                                              want.drive_high));
                if (o_out_data.last !== want.last)
                    report_mismatch($sformatf("pin %0d last %b, expected %b",
                                              want.pin_index, o_out_data.last,
                                              want.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command and register transfers
    // ------------------------------------------------------------------------
    // Called at a clock edge; returns at the edge of the transfer with valid
    // still high, so a following command can be driven without valid going low
    task automatic send_cmd(input logic [ppoc_pkg::OP_W-1:0]    op,
                            input logic [ppoc_pkg::LEVEL_W-1:0] level);
        ppoc_pkg::t_in_item cmd;
        cmd.op    = op;
        cmd.level = level;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= cmd;
        do @(posedge i_clk); while (o_in_stall);
        apply_command(cmd);
    endtask

    // Let every predicted drive arrive, then cover commands with no result still busy
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [ppoc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ppoc_pkg::CFG_DAT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            ppoc_pkg::CFG_POWER_SELECT:     pwr_sel_pin = val;
            ppoc_pkg::CFG_DIRECTION_SELECT: dir_pin     = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_selects(input logic [ppoc_pkg::PIN_W-1:0] pwr,
                               input logic [ppoc_pkg::PIN_W-1:0] dir);
        wait_idle();
        cfg_write(ppoc_pkg::CFG_POWER_SELECT, pwr);
        cfg_write(ppoc_pkg::CFG_DIRECTION_SELECT, dir);
    endtask

    // Mostly a real pin, now and then a select at or past the end of the pin range
    function automatic logic [ppoc_pkg::PIN_W-1:0] rand_pin();
        if ($urandom_range(0, 9) == 0)
            return ppoc_pkg::PIN_W'($urandom_range(NPINS, 31));
        return ppoc_pkg::PIN_W'($urandom_range(0, NPINS - 1));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Plain pin 0 with the reset selects: full level, zero, mid, off, left/right
    task automatic test_plain_pin();
        send_cmd(ppoc_pkg::OP_ON, 8'h00);
        send_cmd(ppoc_pkg::OP_SET_POWER, 8'h00);
        send_cmd(ppoc_pkg::OP_SET_POWER, 8'h80);
        send_cmd(ppoc_pkg::OP_OFF, 8'hff);
        send_cmd(ppoc_pkg::OP_SET_POWER, 8'hc8);
        send_cmd(ppoc_pkg::OP_LEFT, 8'h00);
        send_cmd(ppoc_pkg::OP_RIGHT, 8'h00);
    endtask

    // PWM pin: levels just inside and on the edges of the PWM range
    task automatic test_pwm_pin();
        set_selects(5'd3, 5'd11);
        send_cmd(ppoc_pkg::OP_SET_POWER, 8'h01);
        send_cmd(ppoc_pkg::OP_ON, 8'h00);
        send_cmd(ppoc_pkg::OP_SET_POWER, 8'hfe);
        send_cmd(ppoc_pkg::OP_SET_POWER, 8'hff);
        send_cmd(ppoc_pkg::OP_SET_POWER, 8'h00);
        send_cmd(ppoc_pkg::OP_LEFT, 8'h00);
    endtask

    // Stop all with pins on, with none on, and with the top pin on
    task automatic test_stop_all();
        set_selects(5'd20, 5'd5);
        send_cmd(ppoc_pkg::OP_STOP_ALL, 8'h00);
        send_cmd(ppoc_pkg::OP_STOP_ALL, 8'hff);
        send_cmd(ppoc_pkg::OP_ON, 8'h00);
        send_cmd(ppoc_pkg::OP_LEFT, 8'h00);
        send_cmd(ppoc_pkg::OP_STOP_ALL, 8'h00);
    endtask

    // Spare op codes, selects past the last pin and spare register indexes
    task automatic test_ignored();
        send_cmd(OP_SPARE_A, 8'h55);
        send_cmd(OP_SPARE_B, 8'haa);
        set_selects(5'd21, 5'd31);
        send_cmd(ppoc_pkg::OP_SET_POWER, 8'h10);
        send_cmd(ppoc_pkg::OP_ON, 8'h00);
        send_cmd(ppoc_pkg::OP_OFF, 8'h00);
        send_cmd(ppoc_pkg::OP_LEFT, 8'h00);
        send_cmd(ppoc_pkg::OP_RIGHT, 8'h00);
        wait_idle();
        cfg_write(CFG_SPARE_A, 5'd4);
        cfg_write(CFG_SPARE_B, 5'd31);
        send_cmd(ppoc_pkg::OP_ON, 8'h00);
        set_selects(5'd0, 5'd0);
    endtask

    // Random commands; the pin selects move now and then between bursts
    task automatic test_random(input int unsigned n_items);
        int unsigned                  r;
        logic [ppoc_pkg::OP_W-1:0]    op;
        logic [ppoc_pkg::LEVEL_W-1:0] level;
        for (int unsigned i = 0; i < n_items; i++) begin
            if (i == 0 || $urandom_range(0, 19) == 0) begin
                wait_idle();
                if (i == 0 || $urandom_range(0, 1))
                    cfg_write(ppoc_pkg::CFG_POWER_SELECT, rand_pin());
                if (i == 0 || $urandom_range(0, 1))
                    cfg_write(ppoc_pkg::CFG_DIRECTION_SELECT, rand_pin());
                if ($urandom_range(0, 9) == 0)
                    cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                              ppoc_pkg::CFG_DAT_W'($urandom));
            end
            r = $urandom_range(0, 99);
            if (r < 4)       op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
            else if (r < 34) op = ppoc_pkg::OP_SET_POWER;
            else if (r < 54) op = ppoc_pkg::OP_ON;
            else if (r < 68) op = ppoc_pkg::OP_OFF;
            else if (r < 81) op = ppoc_pkg::OP_LEFT;
            else if (r < 93) op = ppoc_pkg::OP_RIGHT;
            else             op = ppoc_pkg::OP_STOP_ALL;
            case ($urandom_range(0, 7))
                0:       level = 8'h00;
                1:       level = 8'hff;
                2:       level = $urandom_range(0, 1) ? 8'h01 : 8'hfe;
                default: level = ppoc_pkg::LEVEL_W'($urandom);
            endcase
            send_cmd(op, level);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int p = 0; p < NPINS; p++) power_lvl[p] = ppoc_pkg::LEVEL_RESET;
        on_bits     = '0;
        pwr_sel_pin = '0;
        dir_pin     = '0;

        send_gap_pct   = 8;
        recv_stall_pct = 71;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_plain_pin();
        test_pwm_pin();
        test_stop_all();
        test_ignored();

        test_random(120);
        wait_idle();
        send_gap_pct   = 71;
        recv_stall_pct = 8;
        test_random(120);
        wait_idle();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_random(120);

        wait_idle();
        if (mismatch_count == 0 && drive_q.size() == 0) begin
            $display("[pin_power_output_controller_core] OK");
        end else begin
            $display("[pin_power_output_controller_core] ERROR");
        end
        $finish;
    end

endmodule
